// ----- hdl/wws_pkg.sv -----
package wws_pkg;

    // Defaults for the top-level parameters.
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths.
    localparam int POS_BITS   = 16;
    localparam int WIN_BITS   = 16;
    localparam int TADDR_BITS = 10;
    localparam int LG_BITS    = 4;

    // The interpolated window is a Q.31 value and fits in 34 signed bits.
    localparam int WSUM_BITS = 34;
    localparam int FRAC_BITS = 16;
    localparam logic [FRAC_BITS:0] FRAC_ONE = 17'h10000;

    // Limits and reset value of the table length register.
    localparam logic [LG_BITS-1:0] LG_MIN   = 4'd1;
    localparam logic [LG_BITS-1:0] LG_MAX   = 4'd10;
    localparam logic [LG_BITS-1:0] LG_RESET = 4'd10;

    // Configuration port.
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 4;
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE     = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEN_LOG2 = 1'b1;

    localparam logic MODE_INTERP = 1'b0;
    localparam logic MODE_FAST   = 1'b1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_WRITE  = 1'b1;

endpackage

// ----- hdl/wws_scale.sv -----
module wws_scale
    import wws_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [WSUM_BITS-1:0]   window,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] scaled
);

    localparam int PROD_BITS = SAMPLE_BITS + WSUM_BITS;
    localparam int WIDE_BITS = PROD_BITS - 31;
    localparam logic signed [WIDE_BITS-1:0] SAT_MAX =
        WIDE_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [WIDE_BITS-1:0] SAT_MIN = -SAT_MAX - WIDE_BITS'(1);

    logic                          vp_reg;
    logic                          vo_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [SAMPLE_BITS-1:0] scaled_reg;
    logic signed [SAMPLE_BITS-1:0] scaled_next;
    logic signed [WIDE_BITS-1:0]   shifted;

    // Dropping the low 31 bits of a two's complement product rounds towards minus infinity.
    assign shifted = prod_reg[PROD_BITS-1:31];

    always_comb begin
        if (shifted > SAT_MAX) begin
            scaled_next = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (shifted < SAT_MIN) begin
            scaled_next = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            scaled_next = shifted[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            vp_reg <= in_valid;
            vo_reg <= vp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg   <= sample * window;
            scaled_reg <= scaled_next;
        end
    end

    assign out_valid = vo_reg;
    assign scaled    = scaled_reg;

endmodule

// ----- hdl/wavetable_window_scaler_top.sv -----
// Channel   Direction  Handshake         Payload
// s_        in         s_valid/s_ready   kind, position, sample, table_address, table_value
// m_        out        m_valid/m_ready   scaled_sample
// cfg_      in         cfg_wr_en only    cfg_index, cfg_wdata
//
// One beat is taken every cycle while no result waits untaken; a sample beat's result
// passes the index stage, the registered two-port window read, the two weight
// multipliers, the weight sum, the sample multiplier and the saturating output
// register, in that order.
// Reset clears the valid bits and the configuration; the window table is not cleared.
// When a result waits untaken the whole pipeline holds and s_ready is low.
module wavetable_window_scaler_top
    import wws_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [POS_BITS-1:0]           s_position,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic [TADDR_BITS-1:0]         s_table_address,
    input  logic signed [WIN_BITS-1:0]    s_table_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_scaled_sample
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam logic [15:0] DEPTH_MASK = 16'(TABLE_DEPTH - 1);

    logic                 mode_reg;
    logic [LG_BITS-1:0]   lg_reg;

    logic                 adv;
    logic [LG_BITS-1:0]   lg_eff;
    logic [15:0]          len_mask;
    logic [31:0]          pos_scaled;
    logic [15:0]          p1_full;
    logic [15:0]          p2_full;
    logic [15:0]          waddr_full;
    logic [FRAC_BITS-1:0] frac_next;

    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic [ADDR_W-1:0]             p1_reg;
    logic [ADDR_W-1:0]             p2_reg;
    logic [FRAC_BITS:0]            wta_reg;
    logic [FRAC_BITS-1:0]          wtb_reg;
    logic [FRAC_BITS:0]            wta2_reg;
    logic [FRAC_BITS-1:0]          wtb2_reg;
    logic signed [WIN_BITS-1:0]    rd1_reg;
    logic signed [WIN_BITS-1:0]    rd2_reg;
    logic signed [WSUM_BITS-1:0]   proda_reg;
    logic signed [WSUM_BITS-1:0]   prodb_reg;
    logic signed [WSUM_BITS-1:0]   wsum_reg;
    logic signed [SAMPLE_BITS-1:0] samp1_reg, samp2_reg, samp3_reg, samp4_reg;

    logic [WIN_BITS-1:0] mem [TABLE_DEPTH];

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_INTERP;
            lg_reg   <= LG_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODE:     mode_reg <= cfg_wdata[0];
                REG_LEN_LOG2: lg_reg   <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // Index stage: the position times the table length splits into entry and fraction.
    always_comb begin
        if (lg_reg < LG_MIN) begin
            lg_eff = LG_MIN;
        end else if (lg_reg > LG_MAX) begin
            lg_eff = LG_MAX;
        end else begin
            lg_eff = lg_reg;
        end
        len_mask   = 16'((17'd1 << lg_eff) - 17'd1);
        pos_scaled = {16'd0, s_position} << lg_eff;
        p1_full    = pos_scaled[31:16] & len_mask & DEPTH_MASK;
        p2_full    = (pos_scaled[31:16] + 16'd1) & len_mask & DEPTH_MASK;
        // In fast mode a zero fraction leaves the lower entry alone at full weight.
        frac_next  = (mode_reg == MODE_FAST) ? '0 : pos_scaled[15:0];
        waddr_full = 16'(s_table_address) & DEPTH_MASK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid && (s_kind == KIND_SAMPLE);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // A table write lands before any later sample beat reaches the read stage.
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (s_valid && (s_kind == KIND_WRITE)) begin
                mem[waddr_full[ADDR_W-1:0]] <= s_table_value;
            end
            p1_reg    <= p1_full[ADDR_W-1:0];
            p2_reg    <= p2_full[ADDR_W-1:0];
            wta_reg   <= FRAC_ONE - {1'b0, frac_next};
            wtb_reg   <= frac_next;
            samp1_reg <= s_sample;

            rd1_reg   <= $signed(mem[p1_reg]);
            rd2_reg   <= $signed(mem[p2_reg]);
            wta2_reg  <= wta_reg;
            wtb2_reg  <= wtb_reg;
            samp2_reg <= samp1_reg;

            proda_reg <= rd1_reg * $signed({1'b0, wta2_reg});
            prodb_reg <= rd2_reg * $signed({2'b00, wtb2_reg});
            samp3_reg <= samp2_reg;

            wsum_reg  <= proda_reg + prodb_reg;
            samp4_reg <= samp3_reg;
        end
    end

    wws_scale #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (v4_reg),
        .sample   (samp4_reg),
        .window   (wsum_reg),
        .out_valid(m_valid),
        .scaled   (m_scaled_sample)
    );

    // A table write beat must never start a result.
    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_kind == KIND_WRITE)) |=> !v1_reg)
        else $error("table write beat entered the sample pipeline");

    a_sample_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_kind == KIND_SAMPLE)) |=> v1_reg)
        else $error("sample beat lost at the index stage");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> ($stable(v2_reg) && $stable(v4_reg) && $stable(wsum_reg)))
        else $error("pipeline moved during a stall");

    a_weights_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> (({1'b0, wtb_reg} + wta_reg) == FRAC_ONE))
        else $error("interpolation weights do not sum to one");

endmodule
